### design/i3wf_pkg.sv
// Shared types and constants of the 3x3 window image filter.
package i3wf_pkg;

  localparam int PIX_W      = 8;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1024;
  localparam int MIN_SIZE     = 3;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_e;

  localparam logic [MODE_W-1:0] MODE_MEAN     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WMEAN    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LAPLACE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GRADIENT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MEDIAN   = 3'd4;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  // One window column, index 0 is the row above the center.
  typedef pix_t [2:0] col_t;
  // Whole window, index 0 is the left column.
  typedef col_t [2:0] win_t;

  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
    pix_t raw;
  } item_t;

  typedef struct packed {
    logic valid;
    logic last;
    pix_t pixel;
  } res_t;

endpackage

### design/i3wf_if.sv
// Handshake channel interfaces of the 3x3 window image filter.
interface i3wf_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel_in;

  modport source (output valid, output req_type, output pixel_in, input ready);
  modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

interface i3wf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface i3wf_cfg_if import i3wf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/i3wf_col_cell.sv
// One column cell of the sliding 3x3 window.
module i3wf_col_cell import i3wf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  col_t col_i,
  output col_t col_o
);

  col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

### design/i3wf_line_store.sv
// Two line banks selected by row parity, one column address per cycle.
module i3wf_line_store import i3wf_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     rd_sel_i,
  input  logic                     wr_en_i,
  input  logic                     wr_bank_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  pix_t                     wr_data_i,
  output pix_t                     sel_o,
  output pix_t                     oth_o
);

  pix_t bank0_mem [DEPTH];
  pix_t bank1_mem [DEPTH];
  pix_t bank0_q;
  pix_t bank1_q;
  logic sel_q;

  // Reads return the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_bank_i) begin
      bank0_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      bank0_q <= bank0_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_bank_i) begin
      bank1_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      bank1_q <= bank1_mem[rd_addr_i];
      sel_q   <= rd_sel_i;
    end
  end

  assign sel_o = sel_q ? bank1_q : bank0_q;
  assign oth_o = sel_q ? bank0_q : bank1_q;

endmodule

### design/i3wf_filter.sv
// Filter arithmetic on the window: registered stages from window to result.
module i3wf_filter import i3wf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [MODE_W-1:0] mode_i,
  input  item_t             item_i,
  input  win_t              win_i,
  output res_t              res_o
);

  localparam int SumW  = 12;
  localparam int LapW  = 10;
  localparam int ProdW = 25;
  localparam int RecipShift = 16;
  // Reciprocals of 9 and 12 scaled by 2^16, exact after truncation for these sums.
  localparam logic [12:0] MeanRecip  = 13'd7282;
  localparam logic [12:0] WmeanRecip = 13'd5462;
  localparam logic [LapW-1:0] SatIn = LapW'(PIX_MAX >> 2);
  localparam logic [3:0] HalfDiv = 4'd6;

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic pix_t absdiff(input pix_t a, input pix_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  // First stage: sums, differences and the per-row sort of the median.
  pix_t            c_px, up_px, dn_px, lf_px, rt_px;
  logic [SumW-1:0] sum9;
  logic [LapW-1:0] lap_a, lap_b;
  pix_t [2:0]      lo, mi, hi;

  always_comb begin
    c_px  = win_i[1][1];
    up_px = win_i[1][0];
    dn_px = win_i[1][2];
    lf_px = win_i[0][1];
    rt_px = win_i[2][1];
    sum9  = '0;
    for (int j = 0; j < 3; j++) begin
      sum9 = sum9 + SumW'(win_i[j][0]) + SumW'(win_i[j][1]) + SumW'(win_i[j][2]);
    end
    lap_a = {c_px, 2'b00};
    lap_b = LapW'(up_px) + LapW'(dn_px) + LapW'(lf_px) + LapW'(rt_px);
    for (int k = 0; k < 3; k++) begin
      lo[k] = min2(min2(win_i[0][k], win_i[1][k]), win_i[2][k]);
      hi[k] = max2(max2(win_i[0][k], win_i[1][k]), win_i[2][k]);
      mi[k] = med3(win_i[0][k], win_i[1][k], win_i[2][k]);
    end
  end

  item_t           s3_item_q;
  logic [SumW-1:0] s3_mean_x_q, s3_wsum_q;
  logic [LapW-1:0] s3_lap_q;
  pix_t            s3_g1_q, s3_g2_q;
  pix_t [2:0]      s3_lo_q, s3_mi_q, s3_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_item_q <= '0;
    end else begin
      s3_item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_mean_x_q <= sum9 + SumW'(4);
    s3_wsum_q   <= sum9 + SumW'(c_px) + SumW'({c_px, 1'b0});
    s3_lap_q    <= (lap_a > lap_b) ? lap_a - lap_b : lap_b - lap_a;
    s3_g1_q     <= absdiff(c_px, rt_px);
    s3_g2_q     <= absdiff(c_px, up_px);
    s3_lo_q     <= lo;
    s3_mi_q     <= mi;
    s3_hi_q     <= hi;
  end

  // Second stage: reciprocal products, saturation, median partial picks.
  logic [ProdW-1:0] mean_p, wmean_p;
  pix_t             grad_max, lap_sat, grad_sat;

  always_comb begin
    mean_p   = ProdW'(s3_mean_x_q) * ProdW'(MeanRecip);
    wmean_p  = ProdW'(s3_wsum_q) * ProdW'(WmeanRecip);
    grad_max = max2(s3_g1_q, s3_g2_q);
    lap_sat  = (s3_lap_q > SatIn) ? PIX_MAX : {s3_lap_q[5:0], 2'b00};
    grad_sat = (LapW'(grad_max) > SatIn) ? PIX_MAX : {grad_max[5:0], 2'b00};
  end

  item_t           s4_item_q;
  pix_t            s4_mean_q, s4_wq_q, s4_lap_q, s4_grad_q;
  logic [SumW-1:0] s4_wsum_q;
  pix_t            s4_mlo_q, s4_mmi_q, s4_mhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_item_q <= '0;
    end else begin
      s4_item_q <= s3_item_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_mean_q <= mean_p[RecipShift +: PIX_W];
    s4_wq_q   <= wmean_p[RecipShift +: PIX_W];
    s4_wsum_q <= s3_wsum_q;
    s4_lap_q  <= lap_sat;
    s4_grad_q <= grad_sat;
    s4_mlo_q  <= max2(max2(s3_lo_q[0], s3_lo_q[1]), s3_lo_q[2]);
    s4_mmi_q  <= med3(s3_mi_q[0], s3_mi_q[1], s3_mi_q[2]);
    s4_mhi_q  <= min2(min2(s3_hi_q[0], s3_hi_q[1]), s3_hi_q[2]);
  end

  // Last stage: round half to even for the weighted mean, then pick by mode.
  logic [SumW-1:0] rem12;
  logic [3:0]      rem;
  logic            round_up;
  pix_t            wmean, value;

  always_comb begin
    rem12    = s4_wsum_q - SumW'({s4_wq_q, 3'b000}) - SumW'({s4_wq_q, 2'b00});
    rem      = rem12[3:0];
    round_up = (rem > HalfDiv) || ((rem == HalfDiv) && s4_wq_q[0]);
    wmean    = (round_up && (s4_wq_q != PIX_MAX)) ? s4_wq_q + 8'd1 : s4_wq_q;
    value    = s4_item_q.raw;
    if (s4_item_q.interior) begin
      case (mode_i)
        MODE_MEAN:     value = s4_mean_q;
        MODE_WMEAN:    value = wmean;
        MODE_LAPLACE:  value = s4_lap_q;
        MODE_GRADIENT: value = s4_grad_q;
        MODE_MEDIAN:   value = med3(s4_mlo_q, s4_mmi_q, s4_mhi_q);
        default:       value = s4_item_q.raw;
      endcase
    end
  end

  assign res_o.valid = s4_item_q.valid;
  assign res_o.last  = s4_item_q.last;
  assign res_o.pixel = value;

endmodule

### design/image_3x3_window_filter_core.sv
// Top level of the streaming 3x3 window image filter.
// Pixels enter on in_chan in raster order, one beat per pixel (req_type 0).
// Filtered pixels leave on out_chan in raster order, lagging the input by
// image_width+1 pixels; after the last pixel of a frame, flush beats
// (req_type 1) push out the remaining image_width+1 results, and the last
// one carries frame_end. Early flushes and surplus pixels are dropped.
// cfg_chan writes filter_mode, image_width or image_height; a size write
// restarts the frame. Configure only while no result is outstanding.
// Throughput is one pixel per clock while in_chan.ready is high. An accepted
// beat passes the line store read, window shift, two filter stages and the
// output queue write, each one register, before it is ready on out_chan.
// An eight-entry output queue keeps the input open while results wait;
// in_chan.ready drops only when eight results are outstanding, so a stalled
// receiver backs up into the sender after that.
// Reset clears the counters, the window and the queue and restores mean
// mode on a 1024 by 1024 frame. The line store is not cleared.
module image_3x3_window_filter_core import i3wf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input logic         clk_i,
  input logic         rst_ni,
  i3wf_in_if.sink     in_chan,
  i3wf_out_if.source  out_chan,
  i3wf_cfg_if.sink    cfg_chan
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int WCmpW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
  localparam int HCmpW = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                         $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;
  localparam int WRst = (WIDTH_RESET < MAX_WIDTH) ? WIDTH_RESET : MAX_WIDTH;
  localparam int HRst = (HEIGHT_RESET < MAX_HEIGHT) ? HEIGHT_RESET : MAX_HEIGHT;

  typedef struct packed {
    logic last;
    pix_t pixel;
  } beat_t;

  // Configuration.
  logic [MODE_W-1:0] mode_q;
  logic [AW-1:0]     wid_m1_q, wid_m1_d;
  logic [RW-1:0]     hgt_q, hgt_d;
  logic [HW-1:0]     hgt_m1_q, hgt_m1_d;
  logic [WCmpW-1:0]  wv, wcl;
  logic [HCmpW-1:0]  hv, hcl;
  logic              cfg_wr, size_wr;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr  = cfg_chan.valid;
  assign size_wr = cfg_wr && (cfg_chan.index == CFG_IMAGE_WIDTH ||
                              cfg_chan.index == CFG_IMAGE_HEIGHT);

  always_comb begin
    wv = WCmpW'(cfg_chan.data);
    hv = HCmpW'(cfg_chan.data);
    if (wv < WCmpW'(MIN_SIZE)) begin
      wcl = WCmpW'(MIN_SIZE);
    end else if (wv > WCmpW'(MAX_WIDTH)) begin
      wcl = WCmpW'(MAX_WIDTH);
    end else begin
      wcl = wv;
    end
    if (hv < HCmpW'(MIN_SIZE)) begin
      hcl = HCmpW'(MIN_SIZE);
    end else if (hv > HCmpW'(MAX_HEIGHT)) begin
      hcl = HCmpW'(MAX_HEIGHT);
    end else begin
      hcl = hv;
    end
    wid_m1_d = AW'(wcl - WCmpW'(1));
    hgt_d    = RW'(hcl);
    hgt_m1_d = HW'(hcl - HCmpW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_MEAN;
      wid_m1_q <= AW'(WRst - 1);
      hgt_q    <= RW'(HRst);
      hgt_m1_q <= HW'(HRst - 1);
    end else if (cfg_wr) begin
      unique case (cfg_chan.index)
        CFG_FILTER_MODE:  mode_q <= cfg_chan.data[MODE_W-1:0];
        CFG_IMAGE_WIDTH:  wid_m1_q <= wid_m1_d;
        CFG_IMAGE_HEIGHT: begin
          hgt_q    <= hgt_d;
          hgt_m1_q <= hgt_m1_d;
        end
        default: ;
      endcase
    end
  end

  // Raster counters for the input and the output position.
  logic [AW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [HW-1:0] out_row_q, out_row_d;
  logic          acc_in, pix_ok, fl_ok, pix_emit, emit;
  logic          out_last, out_interior;

  assign acc_in   = in_chan.valid && in_chan.ready;
  assign pix_ok   = acc_in && (in_chan.req_type == REQ_PIXEL) && (in_row_q < hgt_q);
  assign fl_ok    = acc_in && (in_chan.req_type == REQ_FLUSH) && !(in_row_q < hgt_q);
  assign pix_emit = pix_ok && ((in_row_q >= RW'(2)) ||
                               ((in_row_q == RW'(1)) && (in_col_q != '0)));
  assign emit     = pix_emit || fl_ok;

  assign out_last     = (out_row_q == hgt_m1_q) && (out_col_q == wid_m1_q);
  assign out_interior = (out_row_q != '0) && (out_row_q != hgt_m1_q) &&
                        (out_col_q != '0) && (out_col_q != wid_m1_q);

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (size_wr || (fl_ok && out_last)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else begin
      if (pix_ok) begin
        if (in_col_q == wid_m1_q) begin
          in_col_d = '0;
          in_row_d = in_row_q + RW'(1);
        end else begin
          in_col_d = in_col_q + AW'(1);
        end
      end
      if (emit) begin
        if (out_col_q == wid_m1_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + HW'(1);
        end else begin
          out_col_d = out_col_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Line store: a pixel reads both banks at its column and writes its own
  // row's bank; a flush reads the stored pixel of the output position.
  pix_t ls_sel, ls_oth;

  i3wf_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (pix_ok || fl_ok),
    .rd_addr_i (fl_ok ? out_col_q : in_col_q),
    .rd_sel_i  (fl_ok ? out_row_q[0] : in_row_q[0]),
    .wr_en_i   (pix_ok),
    .wr_bank_i (in_row_q[0]),
    .wr_addr_i (in_col_q),
    .wr_data_i (in_chan.pixel_in),
    .sel_o     (ls_sel),
    .oth_o     (ls_oth)
  );

  // Stage 1: beat accepted, line store read in progress.
  logic s1_valid_q, s1_emit_q, s1_flush_q, s1_interior_q, s1_last_q;
  pix_t s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= pix_ok || fl_ok;
      s1_emit_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_flush_q    <= fl_ok;
    s1_interior_q <= out_interior;
    s1_last_q     <= fl_ok && out_last;
    s1_pix_q      <= in_chan.pixel_in;
  end

  // Window: three column cells, the new column enters on the right.
  col_t new_col, col0, col1, col2;
  logic win_shift;

  assign win_shift  = s1_valid_q && !s1_flush_q;
  assign new_col[0] = ls_sel;
  assign new_col[1] = ls_oth;
  assign new_col[2] = s1_pix_q;

  i3wf_col_cell u_cell2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (win_shift),
    .col_i   (new_col),
    .col_o   (col2)
  );

  i3wf_col_cell u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (win_shift),
    .col_i   (col2),
    .col_o   (col1)
  );

  i3wf_col_cell u_cell0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (win_shift),
    .col_i   (col1),
    .col_o   (col0)
  );

  // Stage 2: window holds this beat's neighborhood.
  logic  s2_valid_q, s2_flush_q, s2_interior_q, s2_last_q;
  pix_t  s2_fraw_q;
  item_t s2_item;
  win_t  win;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_flush_q    <= s1_flush_q;
    s2_interior_q <= s1_interior_q;
    s2_last_q     <= s1_last_q;
    s2_fraw_q     <= ls_sel;
  end

  // For a pixel beat the output position is the window center.
  assign win              = {col2, col1, col0};
  assign s2_item.valid    = s2_valid_q;
  assign s2_item.interior = s2_interior_q;
  assign s2_item.last     = s2_last_q;
  assign s2_item.raw      = s2_flush_q ? s2_fraw_q : col1[1];

  i3wf_filter u_filter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .item_i (s2_item),
    .win_i  (win),
    .res_o  (res)
  );

  // Output queue with a count of results promised to accepted beats.
  beat_t                 fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] fifo_cnt_q, pend_q;
  logic                  out_acc;

  assign out_acc         = out_chan.valid && out_chan.ready;
  assign out_chan.valid     = (fifo_cnt_q != '0);
  assign out_chan.pixel_out = fifo_q[rd_ptr_q].pixel;
  assign out_chan.frame_end = fifo_q[rd_ptr_q].last;
  assign in_chan.ready      = (pend_q < FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      fifo_q[wr_ptr_q] <= '{last: res.last, pixel: res.pixel};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      pend_q     <= '0;
    end else begin
      if (res.valid) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(res.valid) - FIFO_CNT_W'(out_acc);
      pend_q     <= pend_q + FIFO_CNT_W'(emit) - FIFO_CNT_W'(out_acc);
    end
  end

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("outstanding result count exceeds queue depth");

  a_fifo_le_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= pend_q)
    else $error("queue holds more results than were promised");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fl_ok && out_last) |=> (in_row_q == '0 && out_row_q == '0 && out_col_q == '0))
    else $error("counters not restarted after the last beat of a frame");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_col_q <= wid_m1_q) && (out_col_q <= wid_m1_q) && (in_row_q <= hgt_q))
    else $error("raster counter outside the frame");

endmodule
